>>> src/whmm_pkg.sv
// Shared constants, types and state codes for the windowed history min/mean block.
package whmm_pkg;

    // History geometry.
    localparam int HISTORY_DEPTH = 64;
    localparam int ADDR_W        = $clog2(HISTORY_DEPTH);
    localparam int CNT_W         = $clog2(HISTORY_DEPTH + 1);

    // Field widths.
    localparam int POWER_W    = 32;
    localparam int HALF_W     = 16;
    localparam int CHARGE_W   = 7;
    localparam int SOC_IN_W   = 10;
    localparam int MINUTES_W  = 11;
    localparam int INTERVAL_W = 22;

    // Stream payload widths, rounded up to whole bytes.
    localparam int IN_TDATA_W  = 56;
    localparam int OUT_TDATA_W = 48;

    // Constants of the conversion arithmetic.
    localparam int MS_PER_MIN_W = 16;
    localparam logic [MS_PER_MIN_W-1:0] MS_PER_MINUTE = 16'd60000;
    localparam logic [INTERVAL_W-1:0]   INTERVAL_RESET = 22'd60000;
    localparam int PROD_W = MS_PER_MIN_W + MINUTES_W;

    // Divide by ten as a multiplication by a reciprocal: exact for every 10-bit value.
    localparam int SOC_PROD_W  = 18;
    localparam int DIV10_SHIFT = 11;
    localparam logic [SOC_PROD_W-1:0] DIV10_MUL = 18'd205;

    localparam logic [CHARGE_W-1:0] CHARGE_MAX = '1;

    // Running sum of up to HISTORY_DEPTH signed power values.
    localparam int SUM_W = POWER_W + ADDR_W;

    // Shared divider geometry.
    localparam int DIV_NUM_W = (SUM_W > PROD_W) ? SUM_W : PROD_W;
    localparam int DIV_DEN_W = INTERVAL_W;
    localparam int DIV_CNT_W = $clog2(DIV_NUM_W + 1);

    // Request codes carried on the input tuser.
    localparam logic REQ_PUSH  = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COUNT,
        S_WALK,
        S_MEAN,
        S_MEAN_WAIT,
        S_OUT
    } t_state;

    typedef struct packed {
        logic                 start;
        logic [DIV_NUM_W-1:0] dividend;
        logic [DIV_DEN_W-1:0] divisor;
    } t_div_req;

endpackage

>>> src/whmm_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module whmm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> src/whmm_div.sv
// Serial restoring unsigned divider, one quotient bit per cycle, shared by the query steps.
module whmm_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  whmm_pkg::t_div_req            i_req,
    output logic                          o_done,
    output logic [whmm_pkg::DIV_NUM_W-1:0] o_quotient
);

    logic [whmm_pkg::DIV_CNT_W-1:0] r_cnt;
    logic                           r_done;
    logic [whmm_pkg::DIV_DEN_W-1:0] r_rem;
    logic [whmm_pkg::DIV_DEN_W-1:0] r_den;
    logic [whmm_pkg::DIV_NUM_W-1:0] r_quo;

    logic [whmm_pkg::DIV_DEN_W:0] w_shift;
    logic [whmm_pkg::DIV_DEN_W:0] w_diff;
    logic                         w_fit;

    // Bring down the next dividend bit and try to subtract the divisor.
    always_comb begin
        w_shift = {r_rem, r_quo[whmm_pkg::DIV_NUM_W-1]};
        w_fit   = (w_shift >= {1'b0, r_den});
        w_diff  = w_shift - {1'b0, r_den};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_cnt <= whmm_pkg::DIV_CNT_W'(whmm_pkg::DIV_NUM_W);
            end else if (r_cnt != '0) begin
                r_cnt  <= r_cnt - 1'b1;
                r_done <= (r_cnt == whmm_pkg::DIV_CNT_W'(1));
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= '0;
            r_den <= i_req.divisor;
            r_quo <= i_req.dividend;
        end else if (r_cnt != '0) begin
            r_rem <= w_fit ? w_diff[whmm_pkg::DIV_DEN_W-1:0]
                           : w_shift[whmm_pkg::DIV_DEN_W-1:0];
            r_quo <= {r_quo[whmm_pkg::DIV_NUM_W-2:0], w_fit};
        end
    end

    assign o_done     = r_done;
    assign o_quotient = r_quo;

endmodule

>>> src/windowed_history_min_mean_top.sv
// Top level of the windowed history block: minimum charge and mean power over recent samples.
//
// The block keeps the newest 64 pairs of meter power and battery charge and
// answers window queries over them, taking one item at a time. A push item
// (tuser 0) swaps the 16-bit halves of the power word, divides the charge in
// tenths of a percent by ten and stores the pair, dropping the oldest pair
// once the history is full; its result is offered in the cycle after the
// transfer. A query item (tuser 1) first turns the window in minutes into an
// entry count with the shared serial divider, clamps that count to between
// one and the number of pairs held, then reads the newest n pairs from the
// history memory at one pair per cycle while it tracks the minimum charge
// and the power sum, and finally divides the sum by n in the same divider.
// A query on an empty history returns at once with zeros. The input is not
// ready while an item is being worked on or its result waits to be taken.
// The sample interval register is written through its own channel and should
// be written only while the block is idle; a value of zero is treated as one
// millisecond. History memory contents need no clearing after reset, since
// only written pairs are ever read.
module windowed_history_min_mean_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // Input stream.
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // From bit 0: raw_power_words[31:0], raw_soc_tenths[41:32],
    // window_minutes[52:42], zero padding up to bit 55.
    input  logic [whmm_pkg::IN_TDATA_W-1:0]  s_tdata,
    // Bit 0: req_type.
    input  logic                             s_tuser,
    // Result stream.
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // From bit 0: min_soc_percent[6:0], mean_power_watts[38:7],
    // entries_held[45:39], zero padding up to bit 47.
    output logic [whmm_pkg::OUT_TDATA_W-1:0] m_tdata,
    // Sample interval register write channel.
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [whmm_pkg::INTERVAL_W-1:0]  i_cfg_data
);

    localparam int ADDR_W   = whmm_pkg::ADDR_W;
    localparam int CNT_W    = whmm_pkg::CNT_W;
    localparam int POWER_W  = whmm_pkg::POWER_W;
    localparam int CHARGE_W = whmm_pkg::CHARGE_W;
    localparam int SUM_W    = whmm_pkg::SUM_W;
    localparam int NUM_W    = whmm_pkg::DIV_NUM_W;
    localparam int DEN_W    = whmm_pkg::DIV_DEN_W;

    // Control state.
    whmm_pkg::t_state r_state;
    whmm_pkg::t_state n_state;
    logic [whmm_pkg::INTERVAL_W-1:0] r_interval;
    logic [ADDR_W-1:0] r_slot;
    logic [CNT_W-1:0]  r_fill;
    logic [CNT_W-1:0]  r_issue;
    logic [CNT_W-1:0]  r_got;
    logic              r_pend;

    // Payload registers.
    logic [CNT_W-1:0]          r_n;
    logic [CHARGE_W-1:0]       r_min;
    logic signed [SUM_W-1:0]   r_sum;
    logic [CHARGE_W-1:0]       r_res_min;
    logic [POWER_W-1:0]        r_res_mean;

    // Input fields.
    logic                             w_req_type;
    logic [POWER_W-1:0]               w_raw_power;
    logic [whmm_pkg::SOC_IN_W-1:0]    w_raw_soc;
    logic [whmm_pkg::MINUTES_W-1:0]   w_minutes;

    logic w_in_xfer;
    logic w_out_xfer;
    logic w_push;
    logic w_issue;
    logic w_last;

    logic [POWER_W-1:0]              w_power_swapped;
    logic [whmm_pkg::SOC_PROD_W-1:0] w_soc_prod;
    logic [CHARGE_W-1:0]             w_charge;
    logic [ADDR_W-1:0]               w_slot_next;
    logic [whmm_pkg::PROD_W-1:0]     w_window_ms;
    logic [DEN_W-1:0]                w_interval_eff;
    logic [CNT_W-1:0]                w_n_clamped;
    logic [CNT_W:0]                  w_back;
    logic [CNT_W:0]                  w_base;
    logic [CNT_W:0]                  w_slot_diff;
    logic [ADDR_W-1:0]               w_raddr;
    logic [SUM_W-1:0]                w_sum_mag;
    logic [POWER_W-1:0]              w_quo_low;
    logic signed [SUM_W-1:0]         w_power_ext;

    logic [POWER_W-1:0]  w_rd_power;
    logic [CHARGE_W-1:0] w_rd_charge;

    whmm_pkg::t_div_req       w_div_req;
    logic                     w_div_done;
    logic [NUM_W-1:0]         w_div_quo;

    assign w_req_type  = s_tuser;
    assign w_raw_power = s_tdata[31:0];
    assign w_raw_soc   = s_tdata[41:32];
    assign w_minutes   = s_tdata[52:42];

    assign w_in_xfer  = s_tvalid && s_tready;
    assign w_out_xfer = m_tvalid && m_tready;
    assign w_push     = w_in_xfer && (w_req_type == whmm_pkg::REQ_PUSH);

    assign o_cfg_ready = 1'b1;

    // Push arithmetic: half swap, and charge divided by ten through the reciprocal.
    always_comb begin
        w_power_swapped = {w_raw_power[whmm_pkg::HALF_W-1:0],
                           w_raw_power[POWER_W-1:whmm_pkg::HALF_W]};
        w_soc_prod      = whmm_pkg::SOC_PROD_W'(w_raw_soc) * whmm_pkg::DIV10_MUL;
        w_charge        = w_soc_prod[whmm_pkg::DIV10_SHIFT +: CHARGE_W];
        w_slot_next     = (r_slot == ADDR_W'(whmm_pkg::HISTORY_DEPTH - 1))
                        ? '0 : r_slot + 1'b1;
    end

    // Window length in milliseconds, and the interval with zero read as one.
    always_comb begin
        w_window_ms    = whmm_pkg::PROD_W'(whmm_pkg::MS_PER_MINUTE)
                       * whmm_pkg::PROD_W'(w_minutes);
        w_interval_eff = (r_interval == '0) ? DEN_W'(1) : r_interval;
    end

    // The entry count is clamped to one at least and to the pairs held at most.
    always_comb begin
        if (w_div_quo == '0) begin
            w_n_clamped = CNT_W'(1);
        end else if (w_div_quo > NUM_W'(r_fill)) begin
            w_n_clamped = r_fill;
        end else begin
            w_n_clamped = w_div_quo[CNT_W-1:0];
        end
    end

    // Slot of the k-th newest pair, wrapping below slot zero.
    always_comb begin
        w_back      = {1'b0, r_issue} + 1'b1;
        w_base      = ({1'b0, CNT_W'(r_slot)} >= w_back)
                    ? {1'b0, CNT_W'(r_slot)}
                    : {1'b0, CNT_W'(r_slot)} + (CNT_W + 1)'(whmm_pkg::HISTORY_DEPTH);
        w_slot_diff = w_base - w_back;
        w_raddr     = w_slot_diff[ADDR_W-1:0];
    end

    // Mean arithmetic: the sum is divided as a magnitude and the sign put back.
    always_comb begin
        w_sum_mag   = r_sum[SUM_W-1] ? SUM_W'(-r_sum) : SUM_W'(r_sum);
        w_quo_low   = w_div_quo[POWER_W-1:0];
        w_power_ext = {{(SUM_W - POWER_W){w_rd_power[POWER_W-1]}}, w_rd_power};
        w_last      = r_pend && ((r_got + 1'b1) == r_n);
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            whmm_pkg::S_IDLE: begin
                if (w_in_xfer) begin
                    if ((w_req_type == whmm_pkg::REQ_PUSH) || (r_fill == '0)) begin
                        n_state = whmm_pkg::S_OUT;
                    end else begin
                        n_state = whmm_pkg::S_COUNT;
                    end
                end
            end
            whmm_pkg::S_COUNT: begin
                if (w_div_done) begin
                    n_state = whmm_pkg::S_WALK;
                end
            end
            whmm_pkg::S_WALK: begin
                if (w_last) begin
                    n_state = whmm_pkg::S_MEAN;
                end
            end
            whmm_pkg::S_MEAN: begin
                n_state = whmm_pkg::S_MEAN_WAIT;
            end
            whmm_pkg::S_MEAN_WAIT: begin
                if (w_div_done) begin
                    n_state = whmm_pkg::S_OUT;
                end
            end
            whmm_pkg::S_OUT: begin
                if (w_out_xfer) begin
                    n_state = whmm_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = whmm_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs of the sequencer: handshakes, divider requests and memory reads.
    always_comb begin
        s_tready           = 1'b0;
        m_tvalid           = 1'b0;
        w_issue            = 1'b0;
        w_div_req.start    = 1'b0;
        w_div_req.dividend = NUM_W'(w_window_ms);
        w_div_req.divisor  = w_interval_eff;
        unique case (r_state)
            whmm_pkg::S_IDLE: begin
                s_tready        = 1'b1;
                w_div_req.start = w_in_xfer && (w_req_type == whmm_pkg::REQ_QUERY)
                                  && (r_fill != '0);
            end
            whmm_pkg::S_WALK: begin
                w_issue = (r_issue < r_n);
            end
            whmm_pkg::S_MEAN: begin
                w_div_req.start    = 1'b1;
                w_div_req.dividend = NUM_W'(w_sum_mag);
                w_div_req.divisor  = DEN_W'(r_n);
            end
            whmm_pkg::S_OUT: begin
                m_tvalid = 1'b1;
            end
            whmm_pkg::S_COUNT, whmm_pkg::S_MEAN_WAIT: begin
            end
            default: begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= whmm_pkg::S_IDLE;
            r_interval <= whmm_pkg::INTERVAL_RESET;
            r_slot     <= '0;
            r_fill     <= '0;
            r_issue    <= '0;
            r_got      <= '0;
            r_pend     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_interval <= i_cfg_data;
            end
            if (w_push) begin
                r_slot <= w_slot_next;
                if (r_fill < CNT_W'(whmm_pkg::HISTORY_DEPTH)) begin
                    r_fill <= r_fill + 1'b1;
                end
            end
            if (r_state == whmm_pkg::S_COUNT) begin
                r_issue <= '0;
                r_got   <= '0;
                r_pend  <= 1'b0;
            end else begin
                r_pend <= w_issue;
                if (w_issue) begin
                    r_issue <= r_issue + 1'b1;
                end
                if (r_pend) begin
                    r_got <= r_got + 1'b1;
                end
            end
        end
    end

    // Payload registers: window count, running minimum and sum, and the result.
    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_res_min  <= '0;
            r_res_mean <= '0;
        end
        if (r_state == whmm_pkg::S_COUNT) begin
            r_n   <= w_n_clamped;
            r_min <= whmm_pkg::CHARGE_MAX;
            r_sum <= '0;
        end else if (r_pend) begin
            if (w_rd_charge < r_min) begin
                r_min <= w_rd_charge;
            end
            r_sum <= r_sum + w_power_ext;
        end
        if ((r_state == whmm_pkg::S_MEAN_WAIT) && w_div_done) begin
            r_res_min  <= r_min;
            r_res_mean <= r_sum[SUM_W-1] ? POWER_W'(-w_quo_low) : w_quo_low;
        end
    end

    whmm_ram #(
        .WIDTH (POWER_W),
        .DEPTH (whmm_pkg::HISTORY_DEPTH)
    ) u_power_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_slot),
        .i_wdata (w_power_swapped),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_power)
    );

    whmm_ram #(
        .WIDTH (CHARGE_W),
        .DEPTH (whmm_pkg::HISTORY_DEPTH)
    ) u_charge_ram (
        .i_clk   (i_clk),
        .i_we    (w_push),
        .i_waddr (r_slot),
        .i_wdata (w_charge),
        .i_raddr (w_raddr),
        .o_rdata (w_rd_charge)
    );

    whmm_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (w_div_req),
        .o_done     (w_div_done),
        .o_quotient (w_div_quo)
    );

    assign m_tdata = {(whmm_pkg::OUT_TDATA_W - 46)'(0), r_fill, r_res_mean, r_res_min};

    // The fill count never exceeds the history depth.
    a_fill_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CNT_W'(whmm_pkg::HISTORY_DEPTH))
        else $error("fill count beyond history depth");

    // The clamped window is never empty and never longer than the history.
    a_window_clamped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == whmm_pkg::S_WALK) |-> ((r_n != '0) && (r_n <= r_fill)))
        else $error("window count outside one to entries held");

    // The divider only reports completion while the sequencer waits for it.
    a_div_done_expected: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> ((r_state == whmm_pkg::S_COUNT)
                        || (r_state == whmm_pkg::S_MEAN_WAIT)))
        else $error("divider finished outside a wait state");

    // The walk never reads more pairs than the window holds.
    a_walk_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == whmm_pkg::S_WALK) |-> (r_got <= r_issue) && (r_issue <= r_n))
        else $error("history walk read count out of step");

    // A result is delivered before the next item can be taken.
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_xfer |=> !s_tready)
        else $error("input taken again before the result went out");

endmodule
